[rtl/wbps_pkg.sv]
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies; every other file in rtl/ refers to this package by scope.
package wbps_pkg;

  localparam int MAX_LEN_DEF     = 8;
  localparam int OFFSET_BITS_DEF = 32;

  // Register file widths
  localparam int PAT_BYTES = 8;
  localparam int PAT_W     = 8 * PAT_BYTES;
  localparam int CARE_W    = PAT_BYTES;
  localparam int LEN_W     = 4;
  localparam int SKIP_W    = 32;
  localparam int CFG_W     = PAT_W;
  localparam int CFG_IDX_W = 2;

  // Result field width
  localparam int OFF_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN = 2'd0,
    REG_CARE    = 2'd1,
    REG_LENGTH  = 2'd2,
    REG_SKIP    = 2'd3
  } cfg_reg_e;

  // Control handed from the top level to every window cell
  typedef struct packed {
    logic             advance;
    logic             clear;
    logic [LEN_W-1:0] eff_len;
  } cell_ctrl_t;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] offset;
  } result_t;

endpackage

[rtl/wbps_cell.sv]
// One window cell: holds one region byte, passes it on to the next cell and
// compares the byte it is about to hold with its pattern byte. Uses wbps_pkg.
module wbps_cell #(
  parameter int Idx = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wbps_pkg::cell_ctrl_t      ctrl_i,
  input  logic [7:0]                byte_i,
  input  logic [wbps_pkg::PAT_W-1:0] pattern_i,
  input  logic [wbps_pkg::CARE_W-1:0] care_i,
  output logic [7:0]                byte_o,
  output logic                      hit_o
);

  logic [7:0]                   byte_q;
  logic [7:0]                   byte_d;
  logic [2:0]                   sel;
  logic                         active;
  logic [7:0]                   want;

  // Cell Idx lines up with pattern byte eff_len-1-Idx
  assign sel    = 3'(ctrl_i.eff_len - wbps_pkg::LEN_W'(Idx) - wbps_pkg::LEN_W'(1));
  assign active = wbps_pkg::LEN_W'(Idx) < ctrl_i.eff_len;
  assign want   = pattern_i[{sel, 3'b000} +: 8];
  assign hit_o  = !active || !care_i[sel] || (byte_i == want);

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = '0;
    end else if (ctrl_i.advance) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

[rtl/wbps_out_fifo.sv]
// Two-entry result queue: an output register plus a skid entry, so the scan
// keeps taking bytes while a result waits. Uses wbps_pkg::result_t.
module wbps_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wbps_pkg::result_t data_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output wbps_pkg::result_t data_o,
  output logic              full_o
);

  logic              v0_q, v0_d;
  logic              v1_q, v1_d;
  wbps_pkg::result_t e0_q, e0_d;
  wbps_pkg::result_t e1_q, e1_d;
  logic              pop;

  assign pop = v0_q && !out_stall_i;

  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    e0_d = e0_q;
    e1_d = e1_q;
    if (pop) begin
      if (v1_q) begin
        e0_d = e1_q;
        if (push_i) begin
          e1_d = data_i;
        end else begin
          v1_d = 1'b0;
        end
      end else if (push_i) begin
        e0_d = data_i;
      end else begin
        v0_d = 1'b0;
      end
    end else if (push_i) begin
      // Never full here: the input side is stalled while the skid entry is used
      if (!v0_q) begin
        e0_d = data_i;
        v0_d = 1'b1;
      end else begin
        e1_d = data_i;
        v1_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

  assign out_valid_o = v0_q;
  assign data_o      = e0_q;
  assign full_o      = v1_q;

endmodule

[rtl/wildcard_byte_pattern_scan.sv]
// Wildcard byte pattern scanner, top level: config registers, counters,
// a chain of wbps_cell window cells and the wbps_out_fifo result queue. Uses wbps_pkg.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------
//  input     | in_valid_i / in_stall_o    | data_byte_i, last_byte_i
//  output    | out_valid_o / out_stall_i  | found_o, match_offset_o
//  config    | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// One byte per cycle while not stalled. A byte enters the window cells and is
// compared at every position in the same cycle; its result, if any, is registered in the queue.
// Reset clears the window, counters and queue and loads the register defaults.
// The input stalls only while both result entries are held by a stalled output.
module wildcard_byte_pattern_scan #(
  parameter int MaxLen     = wbps_pkg::MAX_LEN_DEF,
  parameter int OffsetBits = wbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           last_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           found_o,
  output logic [wbps_pkg::OFF_W-1:0]     match_offset_o,
  input  logic                           cfg_we_i,
  input  logic [wbps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wbps_pkg::CFG_W-1:0]     cfg_data_i
);

  // Only the first eight positions can ever be compared
  localparam int Win = (MaxLen < wbps_pkg::PAT_BYTES) ? MaxLen : wbps_pkg::PAT_BYTES;

  logic [wbps_pkg::PAT_W-1:0]  pattern_q;
  logic [wbps_pkg::CARE_W-1:0] care_q;
  logic [wbps_pkg::LEN_W-1:0]  len_q;
  logic [wbps_pkg::SKIP_W-1:0] skip_q;

  logic [OffsetBits-1:0]       bytes_q, bytes_d;
  logic [wbps_pkg::SKIP_W-1:0] matches_q, matches_d;
  logic                        reported_q, reported_d;

  logic [wbps_pkg::LEN_W-1:0]  eff_len;
  logic [wbps_pkg::LEN_W-1:0]  len_m1;
  logic                        accept;
  logic                        live;
  logic                        len_ok;
  logic                        is_match;
  logic                        is_hit;
  logic                        push;
  logic                        fifo_full;
  logic [OffsetBits-1:0]       start;
  logic [wbps_pkg::OFF_W-1:0]  start_sat;
  logic [Win-1:0]              hits;
  logic [7:0]                  win_byte [Win+1];
  wbps_pkg::cell_ctrl_t        ctrl;
  wbps_pkg::result_t           res_in;
  wbps_pkg::result_t           res_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      care_q    <= '1;
      len_q     <= wbps_pkg::LEN_W'(1);
      skip_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wbps_pkg::REG_PATTERN: pattern_q <= cfg_data_i;
        wbps_pkg::REG_CARE:    care_q    <= cfg_data_i[wbps_pkg::CARE_W-1:0];
        wbps_pkg::REG_LENGTH:  len_q     <= cfg_data_i[wbps_pkg::LEN_W-1:0];
        wbps_pkg::REG_SKIP:    skip_q    <= cfg_data_i[wbps_pkg::SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_len = (len_q > wbps_pkg::LEN_W'(Win)) ? wbps_pkg::LEN_W'(Win) : len_q;
  assign len_m1  = eff_len - wbps_pkg::LEN_W'(1);

  assign accept = in_valid_i && !in_stall_o;
  assign live   = accept && !reported_q;

  assign ctrl.advance = live;
  assign ctrl.clear   = accept && last_byte_i;
  assign ctrl.eff_len = eff_len;

  // Window cell chain: cell 0 takes the new byte, each cell feeds the next
  assign win_byte[0] = data_byte_i;

  for (genvar k = 0; k < Win; k++) begin : g_cell
    wbps_cell #(
      .Idx(k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .byte_i   (win_byte[k]),
      .pattern_i(pattern_q),
      .care_i   (care_q),
      .byte_o   (win_byte[k+1]),
      .hit_o    (hits[k])
    );
  end

  assign len_ok   = (eff_len != '0) && (bytes_q >= OffsetBits'(len_m1));
  assign is_match = live && len_ok && (&hits);
  assign is_hit   = is_match && (matches_q == skip_q);
  assign push     = live && (is_hit || last_byte_i);

  assign start = bytes_q - OffsetBits'(len_m1);

  if (OffsetBits > wbps_pkg::OFF_W) begin : g_off_wide
    assign start_sat = (|start[OffsetBits-1:wbps_pkg::OFF_W]) ? '1
                                                              : start[wbps_pkg::OFF_W-1:0];
  end else if (OffsetBits == wbps_pkg::OFF_W) begin : g_off_same
    assign start_sat = start;
  end else begin : g_off_narrow
    assign start_sat = {{(wbps_pkg::OFF_W - OffsetBits){1'b0}}, start};
  end

  assign res_in.found  = is_hit;
  assign res_in.offset = is_hit ? start_sat : '0;

  // Region counters, saturating
  always_comb begin
    bytes_d    = bytes_q;
    matches_d  = matches_q;
    reported_d = reported_q;
    if (ctrl.clear) begin
      bytes_d    = '0;
      matches_d  = '0;
      reported_d = 1'b0;
    end else begin
      if (live && !(&bytes_q)) begin
        bytes_d = bytes_q + OffsetBits'(1);
      end
      if (is_match && !(&matches_q)) begin
        matches_d = matches_q + wbps_pkg::SKIP_W'(1);
      end
      if (is_hit) begin
        reported_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q    <= '0;
      matches_q  <= '0;
      reported_q <= 1'b0;
    end else begin
      bytes_q    <= bytes_d;
      matches_q  <= matches_d;
      reported_q <= reported_d;
    end
  end

  wbps_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_i     (res_in),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .data_o     (res_out),
    .full_o     (fifo_full)
  );

  assign in_stall_o     = fifo_full;
  assign found_o        = res_out.found;
  assign match_offset_o = res_out.offset;

endmodule

[rtl/wbps_check.sv]
// Port-level checks for the wildcard byte pattern scanner, attached by bind.
// Depends on wbps_pkg for field widths.
module wbps_check (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_i,
  input logic                       out_valid_i,
  input logic                       out_stall_i,
  input logic                       found_i,
  input logic [wbps_pkg::OFF_W-1:0] match_offset_i
);

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(found_i) && $stable(match_offset_i))
    else $error("result changed while stalled");

  // A not-found result carries a zero offset
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> match_offset_i == '0)
    else $error("not-found result with nonzero offset");

  // The input only stalls after a result was held back
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_i) |-> $past(out_valid_i && out_stall_i))
    else $error("input stalled without a held result");

  // A result only appears after a request was taken
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && !in_stall_i))
    else $error("result without an accepted request");

  // Leaving reset, nothing is pending
  a_reset_idle: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_i && !in_stall_i)
    else $error("pending state right after reset");

endmodule

bind wildcard_byte_pattern_scan wbps_check u_wbps_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_i    (in_stall_o),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .found_i       (found_o),
  .match_offset_i(match_offset_o)
);
